// ===== hw/rtl/nsvl_pkg.sv =====
`timescale 1ns / 1ps

package nsvl_pkg;

    // Fixed field widths
    localparam int SLOT_W  = 7;
    localparam int COORD_W = 10;
    localparam int IDX_W   = 20;
    localparam int CNT_W   = 8;

    // Register port
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    // Word select (paddr[2]) of the sites-in-use register
    localparam logic REG_SITES_IN_USE = 1'b0;

    // Action codes
    localparam logic ACT_LOAD     = 1'b0;
    localparam logic ACT_CLASSIFY = 1'b1;

    // Request control and load payload travelling down the site row
    typedef struct packed {
        logic               valid;
        logic               load;
        logic [SLOT_W-1:0]  slot;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_req;

endpackage

// ===== hw/rtl/nsvl_cell.sv =====
`timescale 1ns / 1ps

module nsvl_cell #(
    parameter int CELL_ID = 0,
    parameter int COL_W   = 10,
    parameter int ROW_W   = 10,
    parameter int D_W     = 21,
    parameter int SITE_W  = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [nsvl_pkg::CNT_W-1:0]  i_count,
    input  nsvl_pkg::t_req              i_req,
    input  logic [COL_W-1:0]            i_col,
    input  logic [ROW_W-1:0]            i_row,
    input  logic [D_W-1:0]              i_best_d,
    input  logic [SITE_W-1:0]           i_best_site,
    output nsvl_pkg::t_req              o_req,
    output logic [COL_W-1:0]            o_col,
    output logic [ROW_W-1:0]            o_row,
    output logic [D_W-1:0]              o_best_d,
    output logic [SITE_W-1:0]           o_best_site
);
    import nsvl_pkg::*;

    localparam int DX_W = (COORD_W > COL_W) ? COORD_W : COL_W;
    localparam int DY_W = (COORD_W > ROW_W) ? COORD_W : ROW_W;

    // Site coordinates held by this cell
    logic [COORD_W-1:0] r_site_x;
    logic [COORD_W-1:0] r_site_y;

    logic [DX_W-1:0]   w_ax;
    logic [DX_W-1:0]   w_bx;
    logic [DX_W-1:0]   w_dx;
    logic [DY_W-1:0]   w_ay;
    logic [DY_W-1:0]   w_by;
    logic [DY_W-1:0]   w_dy;
    logic [2*DX_W-1:0] n_sq_x;
    logic [2*DY_W-1:0] n_sq_y;

    t_req              r_mid_req;
    logic [COL_W-1:0]  r_mid_col;
    logic [ROW_W-1:0]  r_mid_row;
    logic [D_W-1:0]    r_mid_best_d;
    logic [SITE_W-1:0] r_mid_best_site;
    logic [2*DX_W-1:0] r_sq_x;
    logic [2*DY_W-1:0] r_sq_y;

    logic [D_W-1:0]    w_dist;
    logic              w_active;
    logic              w_take;

    t_req              r_req;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  r_row;
    logic [D_W-1:0]    r_best_d;
    logic [SITE_W-1:0] r_best_site;

    // Latch the site when a load for this slot passes
    always_ff @(posedge i_clk) begin
        if (i_req.valid && (i_req.load == 1'b1) && (int'(i_req.slot) == CELL_ID)) begin
            r_site_x <= i_req.x;
            r_site_y <= i_req.y;
        end
    end

    // Absolute coordinate differences, then squares
    always_comb begin
        w_ax   = DX_W'(r_site_x);
        w_bx   = DX_W'(i_col);
        w_dx   = (w_ax > w_bx) ? (w_ax - w_bx) : (w_bx - w_ax);
        w_ay   = DY_W'(r_site_y);
        w_by   = DY_W'(i_row);
        w_dy   = (w_ay > w_by) ? (w_ay - w_by) : (w_by - w_ay);
        n_sq_x = (2*DX_W)'(w_dx) * (2*DX_W)'(w_dx);
        n_sq_y = (2*DY_W)'(w_dy) * (2*DY_W)'(w_dy);
    end

    // First stage: hold squares with the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_req.valid <= 1'b0;
        end else begin
            r_mid_req <= i_req;
        end
        r_mid_col       <= i_col;
        r_mid_row       <= i_row;
        r_mid_best_d    <= i_best_d;
        r_mid_best_site <= i_best_site;
        r_sq_x          <= n_sq_x;
        r_sq_y          <= n_sq_y;
    end

    // Sum and compare; the first site always takes, ties keep the lower index
    always_comb begin
        w_dist   = D_W'(r_sq_x) + D_W'(r_sq_y);
        w_active = (int'(i_count) > CELL_ID);
        w_take   = r_mid_req.valid && !r_mid_req.load && w_active &&
                   ((CELL_ID == 0) || (w_dist < r_mid_best_d));
    end

    // Second stage: pass on the running best
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else begin
            r_req <= r_mid_req;
        end
        r_col <= r_mid_col;
        r_row <= r_mid_row;
        if (w_take) begin
            r_best_d    <= w_dist;
            r_best_site <= SITE_W'(CELL_ID);
        end else begin
            r_best_d    <= r_mid_best_d;
            r_best_site <= r_mid_best_site;
        end
    end

    assign o_req       = r_req;
    assign o_col       = r_col;
    assign o_row       = r_row;
    assign o_best_d    = r_best_d;
    assign o_best_site = r_best_site;

endmodule

// ===== hw/rtl/nearest_site_voronoi_labeler_top.sv =====
`timescale 1ns / 1ps

// Channel   | Ports                                             | Handshake
// ----------+---------------------------------------------------+---------------------------
// request   | i_action i_site_slot i_site_x i_site_y i_cell_index | start high, busy low
// result    | o_nearest_site o_no_site                            | o_result_valid, one cycle
// register  | psel penable pwrite paddr pwdata prdata pready      | APB write, pready high
//
// One request is taken every cycle; busy stays low.
// A classify request passes through the index split, then every one of the NCELL site cells,
// where NCELL = min(MAX_SITES, 255), and then the output register, which gives its result.
// Load requests walk the same row and write their cell on the way, giving no result.
// Reset is synchronous and clears the valid bits and the sites-in-use register;
// the site coordinates hold no value until loaded. The receiver cannot stall.

module nearest_site_voronoi_labeler_top #(
    parameter int MAX_SITES  = 128,
    parameter int GRID_WIDTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_action,
    input  logic [nsvl_pkg::SLOT_W-1:0]   i_site_slot,
    input  logic [nsvl_pkg::COORD_W-1:0]  i_site_x,
    input  logic [nsvl_pkg::COORD_W-1:0]  i_site_y,
    input  logic [nsvl_pkg::IDX_W-1:0]    i_cell_index,
    output logic                          o_result_valid,
    output logic [nsvl_pkg::SLOT_W-1:0]   o_nearest_site,
    output logic                          o_no_site,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nsvl_pkg::APB_AW-1:0]   paddr,
    input  logic [nsvl_pkg::APB_DW-1:0]   pwdata,
    output logic [nsvl_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import nsvl_pkg::*;

    localparam int NCELL   = (MAX_SITES < 255) ? MAX_SITES : 255;
    localparam int SITE_W  = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int COL_W   = $clog2(GRID_WIDTH);
    localparam int IDX_MAX = (2 ** IDX_W) - 1;
    localparam int ROW_MAX = IDX_MAX / GRID_WIDTH;
    localparam int ROW_W   = (ROW_MAX > 0) ? $clog2(ROW_MAX + 1) : 1;
    localparam int DX_W    = (COORD_W > COL_W) ? COORD_W : COL_W;
    localparam int DY_W    = (COORD_W > ROW_W) ? COORD_W : ROW_W;
    localparam int D_W     = ((DX_W > DY_W) ? 2 * DX_W : 2 * DY_W) + 1;

    // Division by the grid width as a multiply by a rounded-up reciprocal
    localparam int          SHIFT   = IDX_W + $clog2(GRID_WIDTH);
    localparam int          RECIP_W = IDX_W + 1;
    localparam int          PROD_W  = IDX_W + RECIP_W;
    localparam logic [63:0] RECIP   = ((64'd1 << SHIFT) + 64'(GRID_WIDTH) - 64'd1)
                                      / 64'(GRID_WIDTH);

    // Configuration
    logic [CNT_W-1:0] r_sites_in_use;
    logic             w_cfg_wr;

    assign pready   = 1'b1;
    assign busy     = 1'b0;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SITES_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sites_in_use <= '0;
        end else if (w_cfg_wr) begin
            r_sites_in_use <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SITES_IN_USE) ? APB_DW'(r_sites_in_use) : '0;

    // Index split, stage one: take the request and form the reciprocal product
    t_req              n_f1_req;
    t_req              r_f1_req;
    logic [PROD_W-1:0] r_f1_prod;
    logic [IDX_W-1:0]  r_f1_idx;

    always_comb begin
        n_f1_req.valid = start && !busy;
        n_f1_req.load  = (i_action == ACT_LOAD);
        n_f1_req.slot  = i_site_slot;
        n_f1_req.x     = i_site_x;
        n_f1_req.y     = i_site_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_req.valid <= 1'b0;
        end else begin
            r_f1_req <= n_f1_req;
        end
        r_f1_prod <= PROD_W'(i_cell_index) * PROD_W'(RECIP[RECIP_W-1:0]);
        r_f1_idx  <= i_cell_index;
    end

    // Index split, stage two: row from the product, column as the remainder
    logic [ROW_W-1:0] w_quot;
    logic [IDX_W-1:0] w_rem;
    t_req             r_f2_req;
    logic [ROW_W-1:0] r_f2_row;
    logic [COL_W-1:0] r_f2_col;

    always_comb begin
        w_quot = r_f1_prod[SHIFT +: ROW_W];
        w_rem  = r_f1_idx - IDX_W'(IDX_W'(w_quot) * IDX_W'(GRID_WIDTH));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_req.valid <= 1'b0;
        end else begin
            r_f2_req <= r_f1_req;
        end
        r_f2_row <= w_quot;
        r_f2_col <= w_rem[COL_W-1:0];
    end

    // Row of site cells
    t_req              w_req       [0:NCELL];
    logic [COL_W-1:0]  w_col       [0:NCELL];
    logic [ROW_W-1:0]  w_row       [0:NCELL];
    logic [D_W-1:0]    w_best_d    [0:NCELL];
    logic [SITE_W-1:0] w_best_site [0:NCELL];

    assign w_req[0]       = r_f2_req;
    assign w_col[0]       = r_f2_col;
    assign w_row[0]       = r_f2_row;
    assign w_best_d[0]    = '0;
    assign w_best_site[0] = '0;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        nsvl_cell #(
            .CELL_ID (g),
            .COL_W   (COL_W),
            .ROW_W   (ROW_W),
            .D_W     (D_W),
            .SITE_W  (SITE_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_count     (r_sites_in_use),
            .i_req       (w_req[g]),
            .i_col       (w_col[g]),
            .i_row       (w_row[g]),
            .i_best_d    (w_best_d[g]),
            .i_best_site (w_best_site[g]),
            .o_req       (w_req[g+1]),
            .o_col       (w_col[g+1]),
            .o_row       (w_row[g+1]),
            .o_best_d    (w_best_d[g+1]),
            .o_best_site (w_best_site[g+1])
        );
    end

    // Output register: drop loads, flag an empty search
    logic              r_result_valid;
    logic [SLOT_W-1:0] r_nearest_site;
    logic              r_no_site;
    logic              w_empty;

    assign w_empty = (r_sites_in_use == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= w_req[NCELL].valid && !w_req[NCELL].load;
        end
        r_nearest_site <= w_empty ? '0 : SLOT_W'(w_best_site[NCELL]);
        r_no_site      <= w_empty;
    end

    assign o_result_valid = r_result_valid;
    assign o_nearest_site = r_nearest_site;
    assign o_no_site      = r_no_site;

endmodule
